@@ hw/rtl/json_string_escaper_top_assert.svh @@
// assertion macros for the json string escaper
// used by json_string_escaper_top; no other dependencies
`ifndef JSON_STRING_ESCAPER_TOP_ASSERT_SVH
`define JSON_STRING_ESCAPER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define JSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked check that also holds through reset
`define JSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JSE_ASSERT(label, prop, msg)
`define JSE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ hw/rtl/jse_pkg.sv @@
// shared types, constants and helpers of the json string escaper
// no dependencies
package jse_pkg;

  localparam logic [15:0] BufferSizeReset   = 16'd256;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] ByteBackslash = 8'h5C;
  localparam logic [7:0] ByteQuote     = 8'h22;
  localparam logic [7:0] ByteNewline   = 8'h0A;
  localparam logic [7:0] ByteReturn    = 8'h0D;
  localparam logic [7:0] ByteTab       = 8'h09;
  localparam logic [7:0] CtrlLimit     = 8'h20;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharU         = 8'h75;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharLowerA    = 8'h61;
  localparam logic [7:0] ByteNul       = 8'h00;

  // escape lengths in output bytes
  localparam logic [2:0] LenPlain = 3'd1;
  localparam logic [2:0] LenEsc   = 3'd2;
  localparam logic [2:0] LenUni   = 3'd6;
  localparam logic [2:0] LenTerm  = 3'd1;

  // reserve needed ahead of the current count
  localparam logic [16:0] RoomShort = 17'd2;
  localparam logic [16:0] RoomUni   = 17'd7;

  typedef enum logic [1:0] {
    KindPlain,
    KindEsc,
    KindUni,
    KindTerm
  } jse_kind_e;

  // one classified item waiting for the back end
  typedef struct packed {
    jse_kind_e   kind;
    logic [7:0]  data;
    logic [15:0] base;
    logic        trunc;
  } jse_desc_t;

  typedef struct packed {
    logic      valid;
    jse_desc_t desc;
  } jse_push_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CharZero + {4'b0, nib};
    end else begin
      res = CharLowerA + {4'b0, nib} - 8'd10;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/jse_front.sv @@
// front end: accepts items, checks capacity, keeps the running count
// depends on jse_pkg
module jse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              string_start_i,
  input  logic              string_end_i,
  input  logic [15:0]       buffer_size_i,
  input  logic              q_full_i,
  output jse_pkg::jse_push_t push_o
);
  import jse_pkg::*;

  logic [15:0] wt_q, wt_d, wt;
  logic        halted_q, halted_d, h;
  logic        accept, room_short, room_uni;
  jse_kind_e   kind;
  logic [7:0]  data;
  logic [2:0]  len;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // classify the source byte
  always_comb begin
    kind = KindPlain;
    data = in_byte_i;
    len  = LenPlain;
    if (in_byte_i == ByteQuote || in_byte_i == ByteBackslash) begin
      kind = KindEsc;
      len  = LenEsc;
    end else if (in_byte_i == ByteNewline) begin
      kind = KindEsc;
      data = CharN;
      len  = LenEsc;
    end else if (in_byte_i == ByteReturn) begin
      kind = KindEsc;
      data = CharR;
      len  = LenEsc;
    end else if (in_byte_i == ByteTab) begin
      kind = KindEsc;
      data = CharT;
      len  = LenEsc;
    end else if (in_byte_i < CtrlLimit) begin
      kind = KindUni;
      len  = LenUni;
    end
  end

  always_comb begin
    wt         = string_start_i ? 16'd0 : wt_q;
    h          = string_start_i ? 1'b0 : halted_q;
    room_short = ({1'b0, wt} + RoomShort) < {1'b0, buffer_size_i};
    room_uni   = ({1'b0, wt} + RoomUni) < {1'b0, buffer_size_i};
    wt_d       = wt_q;
    halted_d   = halted_q;
    push_o.valid      = 1'b0;
    push_o.desc.kind  = kind;
    push_o.desc.data  = data;
    push_o.desc.base  = wt;
    push_o.desc.trunc = 1'b0;
    if (accept) begin
      wt_d     = wt;
      halted_d = h;
      if (string_end_i) begin
        push_o.valid      = 1'b1;
        push_o.desc.kind  = KindTerm;
        push_o.desc.data  = ByteNul;
        push_o.desc.trunc = h;
        wt_d              = 16'd0;
        halted_d          = 1'b0;
      end else if (!h) begin
        if (!room_short || (kind == KindUni && !room_uni)) begin
          halted_d = 1'b1;
        end else begin
          push_o.valid = 1'b1;
          wt_d         = wt + {13'b0, len};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q     <= 16'd0;
      halted_q <= 1'b0;
    end else begin
      wt_q     <= wt_d;
      halted_q <= halted_d;
    end
  end

endmodule

@@ hw/rtl/jse_queue.sv @@
// short queue of classified items between front and back end
// depends on jse_pkg
module jse_queue #(
  parameter int unsigned Depth = jse_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jse_pkg::jse_push_t push_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output jse_pkg::jse_desc_t data_o
);
  import jse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  jse_desc_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.desc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/jse_back.sv @@
// back end: expands one classified item into its output bytes
// depends on jse_pkg
module jse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  jse_pkg::jse_desc_t q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               is_terminator_o,
  output logic [15:0]        written_count_o,
  output logic               was_truncated_o
);
  import jse_pkg::*;

  logic [2:0]  idx_q, len;
  logic        load, last;
  logic [7:0]  byte_d;
  logic [15:0] count_d;

  logic        out_valid_q, run_last_q, term_q, trunc_q;
  logic [7:0]  out_byte_q;
  logic [15:0] count_q;

  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign last    = (idx_q == len - 3'd1);
  assign q_pop_o = load && last;

  always_comb begin
    len    = LenPlain;
    byte_d = q_data_i.data;
    case (q_data_i.kind)
      KindPlain: begin
        len = LenPlain;
      end
      KindEsc: begin
        len = LenEsc;
        if (idx_q == 3'd0) begin
          byte_d = ByteBackslash;
        end
      end
      KindUni: begin
        len = LenUni;
        case (idx_q)
          3'd0:    byte_d = ByteBackslash;
          3'd1:    byte_d = CharU;
          3'd2:    byte_d = CharZero;
          3'd3:    byte_d = CharZero;
          3'd4:    byte_d = hex_digit(q_data_i.data[7:4]);
          default: byte_d = hex_digit(q_data_i.data[3:0]);
        endcase
      end
      KindTerm: begin
        len    = LenTerm;
        byte_d = ByteNul;
      end
      default: begin
        len = LenPlain;
      end
    endcase
    count_d = (q_data_i.kind == KindTerm) ? q_data_i.base
                                          : q_data_i.base + {13'b0, idx_q} + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last ? 3'd0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_d;
      run_last_q <= last;
      term_q     <= (q_data_i.kind == KindTerm);
      count_q    <= count_d;
      trunc_q    <= (q_data_i.kind == KindTerm) && q_data_i.trunc;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign run_last_o      = run_last_q;
  assign is_terminator_o = term_q;
  assign written_count_o = count_q;
  assign was_truncated_o = trunc_q;

endmodule

@@ hw/rtl/json_string_escaper_top.sv @@
// path: an accepted item is written into the classified-item queue, and its
// bytes then pass one by one through the back end's output register
// throughput unstalled: one output byte per cycle; a plain byte item every cycle,
// an escape holds the back end for 2 bytes, a \u00xx escape for 6
// input stalls only when the classified-item queue (QueueDepth entries) fills
// reset: asynchronous, active low; clears count, halt flag and queue, and
// sets buffer_size to 256; no clearing pass is needed
`include "json_string_escaper_top_assert.svh"
module json_string_escaper_top #(
  parameter int unsigned QueueDepth = jse_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // source bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        string_start_i,
  input  logic        string_end_i,
  // escaped bytes
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        is_terminator_o,
  output logic [15:0] written_count_o,
  output logic        was_truncated_o
);
  import jse_pkg::*;

  // capacity register, including the closing nul
  logic [15:0] buffer_size_q;

  jse_push_t push;
  jse_desc_t q_data;
  logic      q_full, q_valid, q_pop;

  // the user must issue writes only while idle (unchecked); port is always open
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= BufferSizeReset;
    end else if (cfg_valid_i) begin
      buffer_size_q <= cfg_data_i;
    end
  end

  // front: capacity check, running count; one item per cycle unless queue is full
  jse_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .string_start_i (string_start_i),
    .string_end_i   (string_end_i),
    .buffer_size_i  (buffer_size_q),
    .q_full_i       (q_full),
    .push_o         (push)
  );

  // decouples the front from the multi-byte expansion of the back end
  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // back: one output byte per cycle into its register while out_ready_i is high
  jse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .run_last_o      (run_last_o),
    .is_terminator_o (is_terminator_o),
    .written_count_o (written_count_o),
    .was_truncated_o (was_truncated_o)
  );

  // the terminator is always a run of one byte
  `JSE_ASSERT(a_term_is_last, out_valid_o && is_terminator_o |-> run_last_o, "terminator not last")
  // truncation is only reported on the closing nul
  `JSE_ASSERT(a_trunc_on_term, out_valid_o && !is_terminator_o |-> !was_truncated_o, "stray trunc")
  // a taken byte that is not the end of its run is followed by the rest of the run
  `JSE_ASSERT(a_run_continues, out_valid_o && out_ready_i && !run_last_o |=> out_valid_o, "run broken")
  // input back-pressure only comes from a queue holding items
  `JSE_ASSERT(a_stall_has_work, !in_ready_o |-> q_valid, "stall with empty queue")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for json_string_escaper_top: a directed table, then random strings
// predicts every escaped byte in its own model; depends on jse_pkg and json_string_escaper_top
`timescale 1ns / 1ps
module testbench;
  import jse_pkg::*;

  // idle cycles with no handshake on any channel before the run is abandoned
  localparam int unsigned QuietLimit = 2000;
  // cycles allowed after the last result for items that produce nothing
  localparam int unsigned TailCycles = 16;
  localparam int unsigned PlanRows   = 29;
  localparam int unsigned ShownLimit = 40;

  // a row either writes the capacity register or sends one item
  typedef enum logic {
    RowItem,
    RowCapacity
  } row_kind_e;

  // typed rows carry their single expected result, other rows use the predictor
  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] value;
    logic        start;
    logic        term;
    logic        typed;
    logic [7:0]  exp_byte;
    logic [15:0] exp_count;
    logic        exp_trunc;
  } plan_row_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        run_last;
    logic        term;
    logic [15:0] count;
    logic        trunc;
  } escaped_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i     = 16'd0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i      = 8'd0;
  logic        string_start_i = 1'b0;
  logic        string_end_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        is_terminator_o;
  logic [15:0] written_count_o;
  logic        was_truncated_o;

  json_string_escaper_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .string_start_i  (string_start_i),
    .string_end_i    (string_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .run_last_o      (run_last_o),
    .is_terminator_o (is_terminator_o),
    .written_count_o (written_count_o),
    .was_truncated_o (was_truncated_o)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: capacity register, byte count and halt flag of the open string
  int unsigned capacity   = 32'(BufferSizeReset);
  int unsigned str_len    = 0;
  bit          str_halted = 1'b0;
  string       hexchars   = "0123456789abcdef";

  escaped_t    pending_bytes [$];
  escaped_t    head;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;

  // sender burst shaping, used only by the stimulus process
  int unsigned burst_left = 0;
  int unsigned burst_max  = 1;
  int unsigned gap_max    = 1;

  // receiver stall pattern
  bit          sink_stalls = 1'b0;
  int unsigned sink_hold   = 0;

  plan_row_t directed_plan [PlanRows];

  task automatic report_mismatch(input string msg);
    if (mismatches < ShownLimit) begin
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    end
    mismatches++;
  endtask

  // expected results of one accepted item, appended to pending_bytes
  task automatic escape_source(input logic [7:0] c, input logic start, input logic term);
    logic [7:0] seq [6];
    int         n;
    n = 0;
    // a start clears the string state before anything else
    if (start) begin
      str_len    = 0;
      str_halted = 1'b0;
    end
    // terminator: always one NUL carrying the final count and halt flag
    if (term) begin
      pending_bytes.push_back('{ByteNul, 1'b1, 1'b1, 16'(str_len), str_halted});
      str_len    = 0;
      str_halted = 1'b0;
      return;
    end
    // once halted, data bytes vanish until the string is closed or restarted
    if (str_halted) return;
    // every data byte needs room for two more bytes beyond the count
    if (str_len + 2 >= capacity) begin
      str_halted = 1'b1;
      return;
    end
    if (c == ByteQuote || c == ByteBackslash) begin
      seq[0] = ByteBackslash;
      seq[1] = c;
      n = 2;
    end else if (c == ByteNewline) begin
      seq[0] = ByteBackslash;
      seq[1] = CharN;
      n = 2;
    end else if (c == ByteReturn) begin
      seq[0] = ByteBackslash;
      seq[1] = CharR;
      n = 2;
    end else if (c == ByteTab) begin
      seq[0] = ByteBackslash;
      seq[1] = CharT;
      n = 2;
    end else if (c < CtrlLimit) begin
      // other control bytes, NUL included, take the six-byte unicode form
      if (str_len + 7 >= capacity) begin
        str_halted = 1'b1;
        return;
      end
      seq[0] = ByteBackslash;
      seq[1] = CharU;
      seq[2] = CharZero;
      seq[3] = CharZero;
      seq[4] = hexchars[c[7:4]];
      seq[5] = hexchars[c[3:0]];
      n = 6;
    end else begin
      seq[0] = c;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      str_len = (str_len + 1) & 16'hFFFF;
      pending_bytes.push_back('{seq[k], (k == n - 1), 1'b0, 16'(str_len), 1'b0});
    end
  endtask

  // byte mix weighted towards escapes and control bytes
  function automatic logic [7:0] source_byte();
    logic [7:0] pick;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 4))
          0:       pick = ByteQuote;
          1:       pick = ByteBackslash;
          2:       pick = ByteNewline;
          3:       pick = ByteReturn;
          default: pick = ByteTab;
        endcase
      end
      3, 4:    pick = 8'($urandom_range(0, 31));
      default: pick = 8'($urandom_range(0, 255));
    endcase
    return pick;
  endfunction

  // called at a clock edge; returns at the edge where the item is taken
  task automatic send_item(input plan_row_t row);
    int before_n;
    // end of a burst: drop valid for a random gap
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      burst_left = $urandom_range(1, burst_max);
    end
    in_valid_i     <= 1'b1;
    in_byte_i      <= row.value[7:0];
    string_start_i <= row.start;
    string_end_i   <= row.term;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    items_sent++;
    before_n = pending_bytes.size();
    escape_source(row.value[7:0], row.start, row.term);
    // typed rows replace the predicted result by the one written in the table
    if (row.typed) begin
      while (pending_bytes.size() > before_n) void'(pending_bytes.pop_back());
      pending_bytes.push_back('{row.exp_byte, 1'b1, row.term, row.exp_count, row.exp_trunc});
    end
  endtask

  // wait for every expected byte, then allow for items that produce nothing
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] size);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity = 32'(size);
  endtask

  // receiver: always ready, or alternating ready and stall stretches
  always @(posedge clk_i) begin
    if (!sink_stalls) begin
      out_ready_i <= 1'b1;
      sink_hold   <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready_i <= !out_ready_i;
      sink_hold   <= out_ready_i ? $urandom_range(0, 4) : $urandom_range(0, 7);
    end
  end

  // result checker: oldest expectation against each accepted byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_byte_o));
      end else begin
        head = pending_bytes.pop_front();
        if (out_byte_o !== head.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_o, head.data));
        if (run_last_o !== head.run_last)
          report_mismatch($sformatf("run_last %b, want %b", run_last_o, head.run_last));
        if (is_terminator_o !== head.term)
          report_mismatch($sformatf("is_terminator %b, want %b", is_terminator_o, head.term));
        if (written_count_o !== head.count)
          report_mismatch($sformatf("written_count %0d, want %0d", written_count_o, head.count));
        if (was_truncated_o !== head.trunc)
          report_mismatch($sformatf("was_truncated %b, want %b", was_truncated_o, head.trunc));
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("json_string_escaper_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t   row;
    int unsigned target;
    int unsigned len;
    int unsigned shape;
    logic [15:0] size;

    // kind, byte or size, start, end, typed, byte, count, truncated
    directed_plan = '{
      // reset capacity: plain byte opening a string
      '{RowItem,     16'h0041, 1'b1, 1'b0, 1'b1, 8'h41, 16'd1, 1'b0},
      // NUL data byte is a control byte, not an end mark
      '{RowItem,     16'h0000, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0022, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h005C, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h000A, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h000D, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0009, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h001F, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0020, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h00FF, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h00A5, 1'b0, 1'b1, 1'b0, 8'h00, 16'd0, 1'b0},
      // start and end together: empty string, nothing truncated
      '{RowItem,     16'h00FF, 1'b1, 1'b1, 1'b1, 8'h00, 16'd0, 1'b0},
      // capacity 1: every data byte halts
      '{RowCapacity, 16'd1,    1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0078, 1'b1, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h000A, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0000, 1'b0, 1'b1, 1'b1, 8'h00, 16'd0, 1'b1},
      // zero capacity: only the terminator comes out
      '{RowCapacity, 16'd0,    1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0041, 1'b1, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0000, 1'b0, 1'b1, 1'b1, 8'h00, 16'd0, 1'b1},
      // capacity 9: unicode escape just fits, the next byte halts
      '{RowCapacity, 16'd9,    1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0061, 1'b1, 1'b0, 1'b1, 8'h61, 16'd1, 1'b0},
      '{RowItem,     16'h0001, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0062, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0000, 1'b0, 1'b1, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0001, 1'b1, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h0000, 1'b0, 1'b1, 1'b0, 8'h00, 16'd0, 1'b0},
      // largest capacity
      '{RowCapacity, 16'd65535, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0, 1'b0},
      '{RowItem,     16'h007E, 1'b1, 1'b0, 1'b1, 8'h7E, 16'd1, 1'b0},
      '{RowItem,     16'h0000, 1'b0, 1'b1, 1'b1, 8'h00, 16'd1, 1'b0}
    };

    // reset held low from the start, released on a rising edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, sender and receiver both busy with idling
    burst_max = 4;
    gap_max   = 3;
    sink_stalls <= 1'b1;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == RowCapacity) begin
        settle();
        write_capacity(directed_plan[i].value);
      end else begin
        send_item(directed_plan[i]);
      end
    end

    // random part: ten phases, each with its own capacity and idling shape
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      case (phase)
        0:       size = 16'd1;
        1:       size = 16'($urandom_range(3, 12));
        2:       size = 16'd65535;
        3:       size = 16'($urandom_range(8, 30));
        4:       size = 16'd0;
        5:       size = BufferSizeReset;
        6:       size = 16'($urandom_range(0, 65535));
        7:       size = 16'($urandom_range(2, 9));
        8:       size = 16'($urandom_range(13, 40));
        default: size = 16'd2;
      endcase
      write_capacity(size);

      // no idling, sender gaps only, receiver stalls only, or both
      if (phase % 4 == 0 || phase % 4 == 2) begin
        burst_max = 1 << 20;
        gap_max   = 1;
      end else begin
        burst_max = $urandom_range(1, 8);
        gap_max   = $urandom_range(1, 6);
      end
      sink_stalls <= (phase % 4 >= 2);

      // each phase sends at least twenty items; its last string may run past the target
      target = items_sent + 20;
      while (items_sent < target) begin
        shape = $urandom_range(0, 9);
        row   = '0;
        row.kind = RowItem;
        if (shape == 0) begin
          // noise: any mix of start and end on any byte
          row.value = 16'($urandom_range(0, 255));
          row.start = 1'($urandom_range(0, 1));
          row.term  = 1'($urandom_range(0, 1));
          send_item(row);
        end else begin
          // a string, now and then a long one, once in a while left unclosed
          len = (shape == 9) ? $urandom_range(20, 50) : $urandom_range(0, 12);
          row.value = {8'h00, source_byte()};
          row.start = 1'b1;
          send_item(row);
          row.start = 1'b0;
          repeat (len) begin
            row.value = {8'h00, source_byte()};
            send_item(row);
          end
          if (shape != 1) begin
            row.value = 16'($urandom_range(0, 255));
            row.term  = 1'b1;
            send_item(row);
          end
        end
      end
    end

    settle();
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("json_string_escaper_top test passed");
    end else begin
      $display("json_string_escaper_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/jse_pkg.sv
hw/rtl/jse_front.sv
hw/rtl/jse_queue.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper_top.sv
tb/testbench.sv
